/* src/sorted_table_binary_search_macros.svh */
// Assertion macros shared by the sorted table search block.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

`define STBS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stbs assertion failed");

`define STBS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stbs assertion failed");

`else

`define STBS_ASSERT_IMP(label, ante, cons)

`define STBS_ASSERT_NXT(label, ante, cons)

`endif

`endif

/* src/stbs_pkg.sv */
// Types, constants and helpers shared by the sorted table search modules.
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = IDX_W + 1;
  localparam int WORD_W      = 32;
  localparam int POS_W       = 10;
  localparam int CMD_W       = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_ANY    = 3'd2,
    CMD_FIRST  = 3'd3,
    CMD_LAST   = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } st_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PROBE,
    S_CMP,
    S_NBR,
    S_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     clear;
    logic     append;
    logic     init_range;
    logic     rd_mid;
    logic     rd_prev;
    logic     rd_next;
    logic     go_lo;
    logic     go_hi;
    logic     load_res;
    logic     res_found;
    st_code_t res_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic range_empty;
    logic eq;
    logic lt;
    logic mid_first;
    logic mid_last;
    logic res_free;
  } dp_stat_t;

  // Fits a table index to the width of the position field.
  function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
    logic [IDX_W+POS_W-1:0] wide;
    wide = {{POS_W{1'b0}}, idx};
    return wide[POS_W-1:0];
  endfunction

endpackage

/* src/sorted_table_binary_search.sv */
// Top level of the sorted table search block: controller plus datapath.
//
// The block keeps a table of up to 1024 signed 32-bit words, filled by appending and
// assumed sorted ascending. Each input word clears the table, appends a word, or searches
// for a target (any match, first occurrence or last occurrence), and gives exactly one
// result word with a status and a position. Clear, append and unused command codes pass
// through the accept, execute and finish states to the result. A search is set up in the
// execute state and then runs probes, each a read of the midpoint and a compare, since the
// single read port of the table RAM has a registered read; each probe that hits an equal
// word in a first or last occurrence search adds a neighbor read. The finish state waits
// until the output register is free. A new word is accepted as soon as the previous item
// has finished, even while its result still waits in the output register.
module sorted_table_binary_search import stbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic [POS_W-1:0]         out_position
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat)
  );

  stbs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_position (out_position),
    .dp_cmd       (dp_cmd),
    .dp_stat      (dp_stat)
  );

endmodule

/* src/stbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/stbs_ctrl.sv */
// Controller state machine: decodes each command and sequences the search probes.
module stbs_ctrl import stbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_cmd,
  output dp_cmd_t          dp_cmd,
  input  dp_stat_t         dp_stat
);

  state_t   state_r, state_nxt;
  cmd_t     cmd_r, cmd_nxt;
  st_code_t st_r, st_nxt;
  logic     found_r, found_nxt;
  logic     accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    st_r    <= st_nxt;
    found_r <= found_nxt;
  end

  // Next state, together with the result code that the item will report.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    st_nxt    = st_r;
    found_nxt = found_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = cmd_t'(in_cmd);
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        found_nxt = 1'b0;
        st_nxt    = ST_OK;
        state_nxt = S_FIN;
        unique case (cmd_r)
          CMD_APPEND: begin
            if (dp_stat.count_full) begin
              st_nxt = ST_FULL;
            end
          end
          CMD_ANY, CMD_FIRST, CMD_LAST: begin
            if (dp_stat.count_zero) begin
              st_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_PROBE;
            end
          end
          default: begin
          end
        endcase
      end
      S_PROBE: begin
        if (dp_stat.range_empty) begin
          st_nxt    = ST_MISS;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_PROBE;
        unique case (cmd_r)
          CMD_ANY: begin
            if (dp_stat.eq) begin
              found_nxt = 1'b1;
              state_nxt = S_FIN;
            end
          end
          CMD_FIRST: begin
            if (dp_stat.eq && dp_stat.mid_first) begin
              found_nxt = 1'b1;
              state_nxt = S_FIN;
            end else if (dp_stat.eq) begin
              state_nxt = S_NBR;
            end
          end
          CMD_LAST: begin
            if (dp_stat.eq && dp_stat.mid_last) begin
              found_nxt = 1'b1;
              state_nxt = S_FIN;
            end else if (dp_stat.eq) begin
              state_nxt = S_NBR;
            end
          end
          default: begin
            state_nxt = S_FIN;
          end
        endcase
      end
      S_NBR: begin
        // The neighbor differs from the target, so the probed entry is the boundary.
        if (!dp_stat.eq) begin
          found_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_FIN: begin
        if (dp_stat.res_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath commands.
  always_comb begin
    dp_cmd            = '0;
    dp_cmd.res_status = st_r;
    dp_cmd.res_found  = found_r;
    unique case (state_r)
      S_IDLE: begin
        dp_cmd.capture = accept;
      end
      S_EXEC: begin
        unique case (cmd_r)
          CMD_CLEAR: begin
            dp_cmd.clear = 1'b1;
          end
          CMD_APPEND: begin
            dp_cmd.append = !dp_stat.count_full;
          end
          CMD_ANY, CMD_FIRST, CMD_LAST: begin
            dp_cmd.init_range = !dp_stat.count_zero;
          end
          default: begin
          end
        endcase
      end
      S_PROBE: begin
        dp_cmd.rd_mid = !dp_stat.range_empty;
      end
      S_CMP: begin
        unique case (cmd_r)
          CMD_ANY: begin
            dp_cmd.go_lo = !dp_stat.eq && dp_stat.lt;
            dp_cmd.go_hi = !dp_stat.eq && !dp_stat.lt;
          end
          CMD_FIRST: begin
            dp_cmd.rd_prev = dp_stat.eq && !dp_stat.mid_first;
            dp_cmd.go_lo   = !dp_stat.eq && dp_stat.lt;
            dp_cmd.go_hi   = !dp_stat.eq && !dp_stat.lt;
          end
          CMD_LAST: begin
            dp_cmd.rd_next = dp_stat.eq && !dp_stat.mid_last;
            dp_cmd.go_lo   = !dp_stat.eq && dp_stat.lt;
            dp_cmd.go_hi   = !dp_stat.eq && !dp_stat.lt;
          end
          default: begin
          end
        endcase
      end
      S_NBR: begin
        dp_cmd.go_hi = dp_stat.eq && (cmd_r == CMD_FIRST);
        dp_cmd.go_lo = dp_stat.eq && (cmd_r == CMD_LAST);
      end
      S_FIN: begin
        dp_cmd.load_res = dp_stat.res_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/stbs_dp.sv */
// Datapath: table RAM, entry count, search bounds, probe compare and result word.
`include "sorted_table_binary_search_macros.svh"

module stbs_dp import stbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic [POS_W-1:0]         out_position,
  input  dp_cmd_t                  dp_cmd,
  output dp_stat_t                 dp_stat
);

  logic signed [WORD_W-1:0] key_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  // The upper bound is kept as one past the last candidate, so it never goes negative.
  logic [CNT_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         hip1_r, hip1_nxt;
  logic [IDX_W-1:0]         mid_r, mid_nxt;
  logic [CNT_W:0]           bound_sum;
  logic [CNT_W-1:0]         mid_p1;
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r;
  logic [POS_W-1:0]         out_position_r;
  logic                     rd_en;
  logic [IDX_W-1:0]         raddr;
  logic signed [WORD_W-1:0] rdata;

  assign bound_sum = {1'b0, lo_r} + {1'b0, hip1_r} - {{CNT_W{1'b0}}, 1'b1};
  assign mid_nxt   = bound_sum[IDX_W:1];
  assign mid_p1    = {1'b0, mid_r} + {{IDX_W{1'b0}}, 1'b1};

  always_comb begin
    count_nxt = count_r;
    if (dp_cmd.clear) begin
      count_nxt = '0;
    end else if (dp_cmd.append) begin
      count_nxt = count_r + {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    lo_nxt   = lo_r;
    hip1_nxt = hip1_r;
    if (dp_cmd.init_range) begin
      lo_nxt   = '0;
      hip1_nxt = count_r;
    end else if (dp_cmd.go_lo) begin
      lo_nxt = mid_p1;
    end else if (dp_cmd.go_hi) begin
      hip1_nxt = {1'b0, mid_r};
    end
  end

  always_comb begin
    priority if (dp_cmd.rd_prev) begin
      raddr = mid_r - {{(IDX_W-1){1'b0}}, 1'b1};
    end else if (dp_cmd.rd_next) begin
      raddr = mid_p1[IDX_W-1:0];
    end else begin
      raddr = mid_nxt;
    end
  end

  assign rd_en = dp_cmd.rd_mid || dp_cmd.rd_prev || dp_cmd.rd_next;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (dp_cmd.load_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hip1_r <= hip1_nxt;
    if (dp_cmd.capture) begin
      key_r <= in_value;
    end
    if (dp_cmd.rd_mid) begin
      mid_r <= mid_nxt;
    end
    if (dp_cmd.load_res) begin
      out_status_r   <= dp_cmd.res_status;
      out_position_r <= dp_cmd.res_found ? to_pos(mid_r) : '0;
    end
  end

  stbs_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (dp_cmd.append),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (key_r),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign dp_stat.count_zero  = (count_r == '0);
  assign dp_stat.count_full  = (count_r == CNT_W'(TABLE_DEPTH));
  assign dp_stat.range_empty = (lo_r >= hip1_r);
  assign dp_stat.eq          = (rdata == key_r);
  assign dp_stat.lt          = (rdata < key_r);
  assign dp_stat.mid_first   = (mid_r == '0);
  assign dp_stat.mid_last    = (mid_p1 == count_r);
  assign dp_stat.res_free    = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;

  `STBS_ASSERT_IMP(a_no_append_when_full, dp_cmd.append, !dp_stat.count_full)
  `STBS_ASSERT_IMP(a_load_only_when_free, dp_cmd.load_res, !out_valid_r || out_ready)
  `STBS_ASSERT_NXT(a_load_shows_word, dp_cmd.load_res, out_valid_r)
  `STBS_ASSERT_IMP(a_count_in_range, 1'b1, count_r <= CNT_W'(TABLE_DEPTH))
  `STBS_ASSERT_IMP(a_probe_in_range, dp_cmd.rd_mid, lo_r < hip1_r && hip1_r <= count_r)

endmodule

/* tb/sorted_table_binary_search_tb.sv */
// Self-checking testbench for the sorted table search block with a built-in table predictor.
`timescale 1ns / 100ps

module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  localparam int ITEM_TARGET  = 1550;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 600000;
  localparam int REPORT_LIMIT = 10;

  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] value;
    st_code_t          status;
    logic [POS_W-1:0]  pos;
  } answer_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] value;
    logic              fixed_answer;
    st_code_t          status;
    logic [POS_W-1:0]  pos;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd;
  logic signed [WORD_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               out_status;
  logic [POS_W-1:0]         out_position;

  // Predictor copy of the table.
  logic signed [WORD_W-1:0] model_words [TABLE_DEPTH];
  int                       model_fill;

  answer_t pending_answers [$];
  int      mismatch_count = 0;
  int      words_sent     = 0;
  int      cycle_count    = 0;
  bit      tx_idle        = 1'b1;
  bit      rx_idle        = 1'b1;
  bit      hold_request   = 1'b0;

  // Rows without a fixed answer are checked against the predictor.
  stim_row_t directed_rows [0:25] = '{
    '{CMD_ANY,     32'sd0,   1'b1, ST_EMPTY, 10'd0},
    '{CMD_FIRST,   WORD_MAX, 1'b1, ST_EMPTY, 10'd0},
    '{CMD_LAST,    WORD_MIN, 1'b1, ST_EMPTY, 10'd0},
    '{CMD_SPARE_5, -32'sd1,  1'b1, ST_OK,    10'd0},
    '{CMD_APPEND,  WORD_MIN, 1'b1, ST_OK,    10'd0},
    '{CMD_APPEND,  -32'sd1,  1'b1, ST_OK,    10'd0},
    '{CMD_APPEND,  32'sd0,   1'b1, ST_OK,    10'd0},
    '{CMD_APPEND,  32'sd0,   1'b1, ST_OK,    10'd0},
    '{CMD_APPEND,  32'sd0,   1'b1, ST_OK,    10'd0},
    '{CMD_APPEND,  WORD_MAX, 1'b1, ST_OK,    10'd0},
    '{CMD_ANY,     WORD_MIN, 1'b1, ST_OK,    10'd0},
    '{CMD_LAST,    WORD_MAX, 1'b1, ST_OK,    10'd5},
    '{CMD_FIRST,   32'sd0,   1'b0, ST_OK,    10'd0},
    '{CMD_LAST,    32'sd0,   1'b0, ST_OK,    10'd0},
    '{CMD_ANY,     32'sd0,   1'b0, ST_OK,    10'd0},
    '{CMD_ANY,     32'sd1,   1'b1, ST_MISS,  10'd0},
    '{CMD_FIRST,   -32'sd2,  1'b1, ST_MISS,  10'd0},
    '{CMD_LAST,    WORD_MAX - 1, 1'b1, ST_MISS, 10'd0},
    '{CMD_SPARE_6, 32'sd0,   1'b1, ST_OK,    10'd0},
    '{CMD_SPARE_7, WORD_MAX, 1'b1, ST_OK,    10'd0},
    '{CMD_CLEAR,   32'sd0,   1'b1, ST_OK,    10'd0},
    '{CMD_FIRST,   32'sd0,   1'b1, ST_EMPTY, 10'd0},
    '{CMD_APPEND,  32'sd9,   1'b1, ST_OK,    10'd0},
    '{CMD_APPEND,  32'sd4,   1'b1, ST_OK,    10'd0},
    '{CMD_ANY,     32'sd4,   1'b0, ST_OK,    10'd0},
    '{CMD_CLEAR,   WORD_MIN, 1'b1, ST_OK,    10'd0}
  };

  sorted_table_binary_search i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_position (out_position)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Midpoint probing; the first and last occurrence searches also look at the neighbor.
  function automatic bit find_in_table(input logic signed [WORD_W-1:0] target,
                                       input logic [CMD_W-1:0] cmd, output int hit);
    int                       lo;
    int                       hi;
    int                       mid;
    logic signed [WORD_W-1:0] w;
    bit                       boundary_ok;
    lo  = 0;
    hi  = model_fill - 1;
    hit = 0;
    while (lo <= hi) begin
      mid = lo + ((hi - lo) >>> 1);
      w   = model_words[mid];
      case (cmd)
        CMD_FIRST: begin
          if (mid == 0) boundary_ok = 1'b1;
          else boundary_ok = (model_words[mid-1] != target);
          if (w == target && boundary_ok) begin
            hit = mid;
            return 1'b1;
          end
          if (w >= target) hi = mid - 1;
          else lo = mid + 1;
        end
        CMD_LAST: begin
          if (mid == model_fill - 1) boundary_ok = 1'b1;
          else boundary_ok = (model_words[mid+1] != target);
          if (w == target && boundary_ok) begin
            hit = mid;
            return 1'b1;
          end
          if (w <= target) lo = mid + 1;
          else hi = mid - 1;
        end
        default: begin
          if (w == target) begin
            hit = mid;
            return 1'b1;
          end
          if (w < target) lo = mid + 1;
          else hi = mid - 1;
        end
      endcase
    end
    return 1'b0;
  endfunction

  function automatic void predict_table_op(input logic [CMD_W-1:0] cmd,
                                           input logic signed [WORD_W-1:0] value,
                                           output st_code_t status,
                                           output logic [POS_W-1:0] pos);
    int hit;
    status = ST_OK;
    pos    = '0;
    case (cmd)
      CMD_CLEAR: model_fill = 0;
      CMD_APPEND: begin
        if (model_fill < TABLE_DEPTH) begin
          model_words[model_fill] = value;
          model_fill++;
        end else begin
          status = ST_FULL;
        end
      end
      CMD_ANY, CMD_FIRST, CMD_LAST: begin
        if (model_fill == 0) status = ST_EMPTY;
        else if (find_in_table(value, cmd, hit)) pos = POS_W'(hit);
        else status = ST_MISS;
      end
      default: ;
    endcase
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endtask

  // Offers one word and records its expected answer once it is taken.
  task automatic drive_word(input logic [CMD_W-1:0] cmd, input logic signed [WORD_W-1:0] value,
                            input bit fixed_answer = 1'b0, input st_code_t fixed_status = ST_OK,
                            input logic [POS_W-1:0] fixed_pos = '0);
    int               gap;
    answer_t          answer;
    st_code_t         status;
    logic [POS_W-1:0] pos;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= value;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_table_op(cmd, value, status, pos);
    answer.cmd    = cmd;
    answer.value  = value;
    answer.status = fixed_answer ? fixed_status : status;
    answer.pos    = fixed_answer ? fixed_pos : pos;
    pending_answers.push_back(answer);
    words_sent++;
  endtask

  // Drops valid and waits until every answer has come back.
  task automatic drain_answers();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Clear, a run of appends (ascending unless told otherwise), then searches.
  task automatic run_table_episode(input int appends, input int searches, input bit sorted);
    logic signed [WORD_W-1:0] words [$];
    logic signed [WORD_W-1:0] target;
    logic [CMD_W-1:0]         cmd;
    longint                   acc;
    longint                   step;
    int                       pick;
    drive_word(CMD_CLEAR, $urandom);
    case ($urandom_range(0, 3))
      0: acc = longint'(WORD_MIN);
      1: acc = longint'(int'($urandom));
      2: acc = -longint'(appends);
      default: acc = longint'(WORD_MAX) - longint'($urandom_range(0, 40));
    endcase
    for (int i = 0; i < appends; i++) begin
      if (sorted) begin
        if (i != 0) begin
          // Short tables sometimes jump far; long ones stay dense with many repeats.
          if (appends <= 64 && $urandom_range(0, 7) == 0) step = longint'($urandom);
          else step = longint'($urandom_range(0, 2));
          acc += step;
          if (acc > longint'(WORD_MAX)) acc = longint'(WORD_MAX);
        end
        words.push_back(WORD_W'(acc));
      end else if ($urandom_range(0, 3) == 0) begin
        words.push_back($urandom);
      end else begin
        words.push_back(int'($urandom_range(0, 12)) - 6);
      end
      drive_word(CMD_APPEND, words[$]);
    end
    repeat (searches) begin
      pick = $urandom_range(0, 9);
      if (words.size() == 0 || pick == 7) target = $urandom;
      else if (pick <= 5) target = words[$urandom_range(0, words.size() - 1)];
      else if (pick == 6)
        target = words[$urandom_range(0, words.size() - 1)] + ($urandom_range(0, 1) ? 1 : -1);
      else if (pick == 8) target = WORD_MIN;
      else target = WORD_MAX;
      cmd = CMD_W'($urandom_range(CMD_ANY, CMD_LAST));
      drive_word(cmd, target);
    end
  endtask

  task automatic check_answer(input logic [1:0] status, input logic [POS_W-1:0] pos);
    answer_t exp_answer;
    if (pending_answers.size() == 0) begin
      log_mismatch($sformatf("unexpected word: status %0d position %0d", status, pos));
    end else begin
      exp_answer = pending_answers.pop_front();
      if (status !== exp_answer.status || pos !== exp_answer.pos)
        log_mismatch($sformatf({"cmd %0d value %0d: expected status %0d position %0d,",
                                " got status %0d position %0d"},
                               exp_answer.cmd, $signed(exp_answer.value), exp_answer.status,
                               exp_answer.pos, status, pos));
    end
  endtask

  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 7) : 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_answer(out_status, out_position);
    end
  end

  initial begin : stimulus
    int  episode;
    int  kind;
    bit  big_done;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_cmd     <= CMD_CLEAR;
    in_value   <= '0;
    model_fill  = 0;
    episode     = 0;
    big_done    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      drive_word(directed_rows[i].cmd, directed_rows[i].value, directed_rows[i].fixed_answer,
                 directed_rows[i].status, directed_rows[i].pos);
    drain_answers();

    while (words_sent < ITEM_TARGET) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      // One episode runs against a long output stall so the block backs up.
      if (episode == 2) hold_request = 1'b1;
      kind = $urandom_range(0, 7);
      if (!big_done && episode == 5) begin
        run_table_episode(TABLE_DEPTH + $urandom_range(1, 6), 40, 1'b1);
        big_done = 1'b1;
      end else if (kind <= 5) begin
        run_table_episode($urandom_range(0, 24), $urandom_range(3, 14), 1'b1);
      end else if (kind == 6) begin
        run_table_episode($urandom_range(1, 16), $urandom_range(3, 10), 1'b0);
      end else begin
        repeat (10) drive_word(CMD_W'($urandom), $urandom);
      end
      if (episode == 2 || $urandom_range(0, 3) == 0) drain_answers();
      episode++;
    end

    drain_answers();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/stbs_pkg.sv
src/stbs_ram.sv
src/stbs_ctrl.sv
src/stbs_dp.sv
src/sorted_table_binary_search.sv
tb/sorted_table_binary_search_tb.sv
